[hw/rtl/runge_kutta_stage_combiner_defines.svh]
// Assertion macros for the stage combiner RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef RUNGE_KUTTA_STAGE_COMBINER_DEFINES_SVH
`define RUNGE_KUTTA_STAGE_COMBINER_DEFINES_SVH
// same-cycle implication
`define RKSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RKSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/rksc_pkg.sv]
// Shared types, codes, coefficient tables and rounding functions.
// Used by every module of the stage combiner; depends on nothing.
package rksc_pkg;
  localparam int CoefStages = 6;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_DERIV  = 2'd1;
  localparam logic [1:0] FUNC_COMMIT = 2'd2;

  localparam logic [1:0] KIND_APPROX = 2'd0;
  localparam logic [1:0] KIND_FINAL  = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;

  localparam logic [1:0] REG_SOLVER = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;

  localparam logic [30:0] STEP_RESET = 31'd655;

  typedef logic signed [31:0] word_t;
  typedef word_t slope_vec_t [CoefStages];

  typedef struct packed {
    logic       start;
    logic       kind;
    logic       fin;
    logic [2:0] target;
    logic [2:0] count;
  } mac_ctl_t;

  localparam word_t APPROX [2][6][6] = '{
    '{'{0, 0, 0, 0, 0, 0},
      '{8388608, 0, 0, 0, 0, 0},
      '{0, 8388608, 0, 0, 0, 0},
      '{0, 0, 16777216, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0}},
    '{'{0, 0, 0, 0, 0, 0},
      '{4194304, 0, 0, 0, 0, 0},
      '{1572864, 4718592, 0, 0, 0, 0},
      '{14753565, -54982228, 55715325, 0, 0, 0},
      '{34098138, -134217728, 120351179, -3454373, 0, 0},
      '{-4971027, 33554432, -23180684, 7599621, -4613734, 0}}
  };

  localparam word_t FOURTH [2][6] = '{
    '{2796203, 5592405, 5592405, 2796203, 0, 0},
    '{1941807, 0, 9209482, 8981370, -3355443, 0}
  };

  localparam word_t FIFTH [6] = '{1988411, 0, 8707146, 8491477, -3019899, 610081};

  function automatic word_t sat_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic word_t round_q24(input logic signed [63:0] a);
    logic signed [63:0] s;
    s = (a + 64'sd8388608) >>> 24;
    return sat_word(s);
  endfunction

  function automatic word_t round_q16(input logic signed [63:0] a);
    logic signed [63:0] s;
    s = (a + 64'sd32768) >>> 16;
    return sat_word(s);
  endfunction
endpackage

[hw/rtl/rksc_slope_mem.sv]
// Banked slope store: one synchronous memory per stage, all read at one element.
// Depends on rksc_pkg.
module rksc_slope_mem #(
  parameter int STATE_ELEMENTS = 64,
  parameter int MAX_STAGES = 6,
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [2:0]          wstage,
  input  logic [AW-1:0]       waddr,
  input  rksc_pkg::word_t     wdata,
  input  logic [AW-1:0]       raddr,
  output rksc_pkg::slope_vec_t rdata
);
  import rksc_pkg::*;

  for (genvar b = 0; b < CoefStages; b++) begin : g_bank
    if (b < MAX_STAGES) begin : g_mem
      word_t mem [STATE_ELEMENTS];
      always_ff @(posedge clk) begin
        if (we && wstage == 3'(b)) begin
          mem[waddr] <= wdata;
        end
        rdata[b] <= mem[raddr];
      end
    end else begin : g_none
      assign rdata[b] = '0;
    end
  end
endmodule

[hw/rtl/rksc_mac.sv]
// Sequential multiply-accumulate of slopes: stage or 4th order sum, and 5th order sum.
// Depends on rksc_pkg.
module rksc_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  rksc_pkg::mac_ctl_t   ctl,
  input  rksc_pkg::word_t      base,
  input  rksc_pkg::slope_vec_t slopes,
  output logic                 done,
  output rksc_pkg::word_t      r4,
  output rksc_pkg::word_t      r5
);
  import rksc_pkg::*;

  logic               busy;
  logic               pv;
  logic [2:0]         j;
  logic               kind;
  logic               fin;
  logic [2:0]         target;
  logic [2:0]         count;
  logic signed [63:0] p4, p5, acc4, acc5;
  word_t              c4;

  assign c4 = fin ? FOURTH[kind][j] : APPROX[kind][target][j];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      j    <= '0;
    end else if (ctl.start) begin
      busy   <= 1'b1;
      pv     <= 1'b0;
      done   <= 1'b0;
      j      <= '0;
      kind   <= ctl.kind;
      fin    <= ctl.fin;
      target <= ctl.target;
      count  <= ctl.count;
      acc4   <= {{8{base[31]}}, base, 24'd0};
      acc5   <= {{8{base[31]}}, base, 24'd0};
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (j < count) begin
          p4 <= 64'(c4 * slopes[j]);
          p5 <= 64'(FIFTH[j] * slopes[j]);
          pv <= 1'b1;
          j  <= j + 3'd1;
        end else begin
          pv <= 1'b0;
        end
        if (pv) begin
          acc4 <= acc4 + p4;
          acc5 <= acc5 + p5;
        end
        if (j == count && !pv) begin
          busy <= 1'b0;
          done <= 1'b1;
          r4   <= round_q24(acc4);
          r5   <= round_q24(acc5);
        end
      end
    end
  end
endmodule

[hw/rtl/runge_kutta_stage_combiner.sv]
// Stage combiner top: state and result memories, control sequencer, output register.
// Path to the output register: load via S_OUT; derivative via S_RD, S_MAC (serial
// multiply-accumulate over the stored slopes), S_ERR, S_OUT; commit via S_SWEEP (one element
// copied per cycle through the result memory read port), S_OUT. One item at a time: the next
// item is accepted in the cycle after the result is registered, later while the output stalls.
// Reset restores control and configuration, clears the error peak and out_valid; memories hold.
module runge_kutta_stage_combiner #(
  parameter int STATE_ELEMENTS = 64,
  parameter int MAX_STAGES = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [2:0]  stage,
  input  logic [5:0]  element,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] result_value,
  output logic [1:0]  result_kind,
  output logic [2:0]  next_stage,
  output logic [30:0] element_error,
  output logic [30:0] max_error
);
  import rksc_pkg::*;
  `include "runge_kutta_stage_combiner_defines.svh"

  localparam int AW = (STATE_ELEMENTS > 1) ? $clog2(STATE_ELEMENTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_ERR   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;

  logic [2:0]  state;
  logic        solver_kind;
  logic [30:0] time_step;
  logic [30:0] peak;

  word_t state_mem [STATE_ELEMENTS];
  word_t result_mem [STATE_ELEMENTS];
  word_t state_rd, result_rd;

  logic          accept, elem_ok, stage_ok;
  logic [2:0]    stages;
  logic [AW-1:0] addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] h_addr;
  logic [2:0]    h_stage;
  logic          h_fin, h_kind;
  logic signed [63:0] prod;
  word_t         slope;
  slope_vec_t    bank_rd, sl;
  mac_ctl_t      ctl;
  logic          mac_done;
  word_t         r4, r5;
  logic signed [32:0] diff, adiff;
  logic [30:0]   err;

  logic [AW:0]   cnt;
  logic          swv;
  logic [AW-1:0] swaddr;

  word_t         p_value;
  logic [1:0]    p_kind;
  logic [2:0]    p_next;
  logic [30:0]   p_err, p_peak;
  logic          p_wres, p_clr;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign stages    = solver_kind ? 3'd6 : 3'd4;
  assign elem_ok   = 32'(element) < STATE_ELEMENTS;
  assign stage_ok  = (stage < stages) && (32'(stage) < MAX_STAGES);
  assign addr      = AW'(element);
  assign raddr     = (state == S_IDLE) ? addr : h_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      solver_kind <= 1'b0;
      time_step   <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOLVER: solver_kind <= cfg_data[0];
        REG_STEP:   time_step   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (swv) begin
      state_mem[swaddr] <= result_rd;
    end else if (accept && func == FUNC_LOAD && elem_ok) begin
      state_mem[addr] <= value;
    end
    state_rd <= state_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && p_wres && (!out_valid || !out_stall)) begin
      result_mem[h_addr] <= p_value;
    end
    result_rd <= result_mem[cnt[AW-1:0]];
  end

  assign slope = round_q16(prod);

  always_comb begin
    for (int b = 0; b < CoefStages; b++) begin
      sl[b] = (3'(b) == h_stage) ? slope : bank_rd[b];
    end
  end

  rksc_slope_mem #(
    .STATE_ELEMENTS(STATE_ELEMENTS),
    .MAX_STAGES(MAX_STAGES),
    .AW(AW)
  ) u_slopes (
    .clk(clk),
    .we(state == S_RD),
    .wstage(h_stage),
    .waddr(h_addr),
    .wdata(slope),
    .raddr(raddr),
    .rdata(bank_rd)
  );

  assign ctl.start  = (state == S_RD);
  assign ctl.kind   = h_kind;
  assign ctl.fin    = h_fin;
  assign ctl.target = h_stage + 3'd1;
  assign ctl.count  = h_stage + 3'd1;

  rksc_mac u_mac (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .base(state_rd),
    .slopes(sl),
    .done(mac_done),
    .r4(r4),
    .r5(r5)
  );

  assign diff  = 33'(r5) - 33'(r4);
  assign adiff = diff[32] ? -diff : diff;
  assign err   = (adiff > 33'sd2147483647) ? 31'h7fffffff : adiff[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      peak      <= '0;
      out_valid <= 1'b0;
      swv       <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            h_addr  <= addr;
            h_stage <= stage;
            h_kind  <= solver_kind;
            h_fin   <= (stage + 3'd1 == stages);
            prod    <= $signed({1'b0, time_step}) * value;
            p_wres  <= 1'b0;
            p_clr   <= 1'b0;
            p_next  <= '0;
            p_err   <= '0;
            p_peak  <= peak;
            if (func == FUNC_COMMIT) begin
              cnt   <= '0;
              state <= S_SWEEP;
            end else if (func == FUNC_LOAD && elem_ok) begin
              p_value <= value;
              p_kind  <= KIND_APPROX;
              state   <= S_OUT;
            end else if (func == FUNC_DERIV && elem_ok && stage_ok) begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_MAC;
        S_MAC: begin
          if (mac_done) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          p_value <= r4;
          if (h_fin) begin
            p_kind <= KIND_FINAL;
            p_wres <= 1'b1;
            if (h_kind) begin
              p_err  <= err;
              p_peak <= (err > peak) ? err : peak;
            end
          end else begin
            p_kind <= KIND_APPROX;
            p_next <= h_stage + 3'd1;
          end
          state <= S_OUT;
        end
        S_SWEEP: begin
          if (32'(cnt) < STATE_ELEMENTS) begin
            swv    <= 1'b1;
            swaddr <= cnt[AW-1:0];
            cnt    <= cnt + 1'b1;
          end else begin
            swv <= 1'b0;
            if (!swv) begin
              p_value <= '0;
              p_kind  <= KIND_COMMIT;
              p_clr   <= 1'b1;
              state   <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            result_value  <= p_value;
            result_kind   <= p_kind;
            next_stage    <= p_next;
            element_error <= p_err;
            max_error     <= p_peak;
            peak          <= p_clr ? 31'd0 : p_peak;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RKSC_ASSERT_NOW(a_done_in_mac, mac_done, state == S_MAC, "accumulate done outside MAC")
  `RKSC_ASSERT_NEXT(a_deriv_reads, accept && func == FUNC_DERIV && elem_ok && stage_ok, state == S_RD, "derivative did not start read")
  `RKSC_ASSERT_NOW(a_err_final, out_valid && element_error != 31'd0, result_kind == KIND_FINAL, "error on non-final result")
  `RKSC_ASSERT_NOW(a_sweep_write, swv, state == S_SWEEP, "state write outside commit")
endmodule

[tb/tb_runge_kutta_stage_combiner.sv]
// Self-checking testbench for runge_kutta_stage_combiner (RK4 and Fehlberg stage combining).
// Needs rksc_pkg for codes and coefficient tables; driver and monitor use the in/out handshakes.
`timescale 1ns / 1ps

module tb_runge_kutta_stage_combiner;
  import rksc_pkg::*;

  localparam int NELEM = 64;
  localparam int NSTAGE = 6;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [2:0]  stage;
    logic [5:0]  element;
    logic [31:0] value;
  } op_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  kind;
    logic [2:0]  nstage;
    logic [30:0] err;
    logic [30:0] peak;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_SOLVER;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_LOAD;
  logic [2:0] stage = '0;
  logic [5:0] element = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0] result_kind;
  logic [2:0] next_stage;
  logic [30:0] element_error;
  logic [30:0] max_error;

  runge_kutta_stage_combiner uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   cfg_writes = 0;
  logic accepted = 1'b0;

  // predictor state
  logic [31:0] p_state [NELEM];
  logic [31:0] p_slope [NSTAGE][NELEM];
  logic [31:0] p_fourth [NELEM];
  logic [30:0] p_peak = '0;
  logic        p_kind = 1'b0;
  logic [30:0] p_step = STEP_RESET;

  // stimulus-side tracking of written entries
  bit st_ok [NELEM];
  bit sl_ok [NSTAGE][NELEM];
  bit res_ok [NELEM];
  logic gen_kind = 1'b0;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mix_slopes(int e, int cnt, int tgt, int sel);
    longint acc;
    longint c;
    acc = longint'($signed(p_state[e])) * 64'sd16777216;
    for (int j = 0; j < cnt; j++) begin
      if (sel == 0) c = APPROX[p_kind][tgt][j];
      else if (sel == 1) c = FOURTH[p_kind][j];
      else c = FIFTH[j];
      acc += c * longint'($signed(p_slope[j][e]));
    end
    return clamp32((acc + 64'sd8388608) >>> 24);
  endfunction

  task automatic predict(op_t op);
    res_t r;
    int stages;
    int s;
    int e;
    longint d;
    logic [31:0] r5;
    stages = p_kind ? 6 : 4;
    s = op.stage;
    e = op.element;
    r = '{default: '0};
    if (op.func == FUNC_COMMIT) begin
      for (int i = 0; i < NELEM; i++) p_state[i] = p_fourth[i];
      r.kind = KIND_COMMIT;
      r.peak = p_peak;
      p_peak = '0;
      expected_results.push_back(r);
    end else if (op.func == FUNC_LOAD) begin
      p_state[e] = op.value;
      r.value = op.value;
      r.kind = KIND_APPROX;
      r.peak = p_peak;
      expected_results.push_back(r);
    end else if (op.func == FUNC_DERIV && s < stages) begin
      p_slope[s][e] = clamp32((longint'(p_step) * longint'($signed(op.value)) + 32768) >>> 16);
      if (s + 1 < stages) begin
        r.value = mix_slopes(e, s + 1, s + 1, 0);
        r.kind = KIND_APPROX;
        r.nstage = s + 1;
      end else begin
        r.value = mix_slopes(e, stages, 0, 1);
        p_fourth[e] = r.value;
        r.kind = KIND_FINAL;
        if (p_kind) begin
          r5 = mix_slopes(e, stages, 0, 2);
          d = longint'($signed(r5)) - longint'($signed(r.value));
          if (d < 0) d = -d;
          if (d > 64'sd2147483647) d = 64'sd2147483647;
          r.err = d[30:0];
          if (r.err > p_peak) p_peak = r.err;
        end
      end
      r.peak = p_peak;
      expected_results.push_back(r);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // accept side: predict on each input transaction, track config writes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    accepted <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) predict('{func, stage, element, value});
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SOLVER) p_kind = cfg_data[0];
      else if (cfg_index == REG_STEP) p_step = cfg_data[30:0];
      cfg_writes <= cfg_writes + 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", result_value, '0);
      end else begin
        w = expected_results.pop_front();
        if (result_value !== w.value) report("result_value", result_value, w.value);
        if (result_kind !== w.kind) report("result_kind", result_kind, w.kind);
        if (next_stage !== w.nstage) report("next_stage", next_stage, w.nstage);
        if (element_error !== w.err) report("element_error", element_error, w.err);
        if (max_error !== w.peak) report("max_error", max_error, w.peak);
      end
    end
  end

  // driver: bursts of transactions with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    op_t op;
    if (!rst && (!in_valid || accepted)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        func <= op.func;
        stage <= op.stage;
        element <= op.element;
        value <= op.value;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  int stall_span = 0;
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= stall_span[4];
    endcase
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2) == 0 ? 32'h0 : 32'hffffffff;
      3, 4, 5: return $urandom_range(0, 1 << 19) - (1 << 18);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [1:0] f, int s, int e, logic [31:0] v);
    int stages;
    stages = gen_kind ? 6 : 4;
    pending_ops.push_back('{f, s[2:0], e[5:0], v});
    if (f == FUNC_LOAD) st_ok[e] = 1;
    if (f == FUNC_DERIV && s < stages) begin
      sl_ok[s][e] = 1;
      if (s == stages - 1) res_ok[e] = 1;
    end
  endtask

  function automatic bit deriv_legal(int s, int e);
    if (!st_ok[e]) return 0;
    for (int j = 0; j < s; j++) if (!sl_ok[j][e]) return 0;
    return 1;
  endfunction

  function automatic bit commit_legal();
    foreach (res_ok[i]) if (!res_ok[i]) return 0;
    return 1;
  endfunction

  task automatic queue_pass(int e, bit with_load);
    int stages;
    stages = gen_kind ? 6 : 4;
    if (with_load || !st_ok[e]) queue_op(FUNC_LOAD, 0, e, pick_value());
    for (int s = 0; s < stages; s++) queue_op(FUNC_DERIV, s, e, pick_value());
  endtask

  task automatic queue_random(int n);
    int cnt;
    int r;
    int s;
    int e;
    int stages;
    int stop;
    cnt = 0;
    stages = gen_kind ? 6 : 4;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      e = $urandom_range(0, NELEM - 1);
      if (r < 60) begin
        if (!st_ok[e] || $urandom_range(0, 9) < 3) begin
          queue_op(FUNC_LOAD, 0, e, pick_value());
          cnt++;
        end
        stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, stages - 1) : stages;
        for (s = 0; s < stop; s++) queue_op(FUNC_DERIV, s, e, pick_value());
        cnt += stop;
      end else if (r < 75) begin
        s = $urandom_range(0, stages - 1);
        if (deriv_legal(s, e)) queue_op(FUNC_DERIV, s, e, pick_value());
        else queue_op(FUNC_LOAD, 0, e, pick_value());
        cnt++;
      end else if (r < 83) begin
        queue_op(FUNC_LOAD, 0, e, pick_value());
        cnt++;
      end else if (r < 88) begin
        if (commit_legal()) queue_op(FUNC_COMMIT, $urandom_range(0, 7), e, $urandom);
        else queue_op(FUNC_LOAD, 0, e, pick_value());
        cnt++;
      end else if (r < 94) begin
        queue_op(FUNC_UNUSED, $urandom_range(0, 7), e, $urandom);
      end else begin
        queue_op(FUNC_DERIV, $urandom_range(stages, 7), e, $urandom);
      end
    end
  endtask

  task automatic drain();
    while (!(pending_ops.size() == 0 && !in_valid && expected_results.size() == 0)) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    int seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    wait (cfg_writes != seen);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SOLVER) gen_kind = d[0];
  endtask

  initial begin
    logic [31:0] steps [6];
    steps = '{32'h7fffffff, 32'd0, 32'd65536, 32'd655, 32'd1, 32'd0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, ignored codes, then fill every element and commit
    queue_op(FUNC_LOAD, 0, 0, 32'h7fffffff);
    queue_op(FUNC_LOAD, 0, 63, 32'h80000000);
    queue_op(FUNC_UNUSED, 7, 63, 32'hffffffff);
    queue_op(FUNC_DERIV, 4, 0, 32'h12345678);
    queue_op(FUNC_DERIV, 7, 5, 32'h0);
    for (int s = 0; s < 4; s++) queue_op(FUNC_DERIV, s, 0, 32'h7fffffff);
    for (int s = 0; s < 4; s++) queue_op(FUNC_DERIV, s, 63, 32'h80000000);
    for (int e = 0; e < NELEM; e++) queue_pass(e, e != 0 && e != 63);
    queue_op(FUNC_COMMIT, 7, 63, 32'hffffffff);
    drain();

    write_reg(REG_SOLVER, 32'd1);
    write_reg(REG_STEP, 32'h7fffffff);
    for (int s = 0; s < 6; s++) queue_op(FUNC_DERIV, s, 1, 32'h7fffffff);
    for (int s = 0; s < 6; s++) queue_op(FUNC_DERIV, s, 2, 32'h80000000);
    queue_op(FUNC_DERIV, 6, 2, 32'h1);
    queue_op(FUNC_COMMIT, 0, 0, 32'h0);
    drain();

    for (int p = 0; p < 12; p++) begin
      write_reg(REG_SOLVER, p[0] ? 32'd0 : 32'd1);
      if (p < 6) write_reg(REG_STEP, steps[p]);
      else write_reg(REG_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 18));
      queue_random(110);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
